>>> rtl/dna_pwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_pwm_pkg
// Shared types, constants and the base decoder for the PWM window scorer.
// ----------------------------------------------------------------------------
package dna_pwm_pkg;

	// Motif geometry.
	localparam int MAX_MOTIF_LENGTH = 32;
	localparam int POS_W            = $clog2(MAX_MOTIF_LENGTH);
	localparam int LEN_W            = POS_W + 1;
	localparam int NUM_BASES        = 4;
	localparam int BASE_W           = 2;

	// Weight and score widths.
	localparam int WEIGHT_BITS = 16;
	localparam int GROUP       = 4;
	localparam int G2          = MAX_MOTIF_LENGTH / GROUP;
	localparam int G3          = G2 / GROUP;
	localparam int S2_W        = WEIGHT_BITS + 2;
	localparam int S3_W        = S2_W + 2;
	localparam int SCORE_W     = 21;

	// Item opcodes.
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_BASE = 1'b1;

	// Base codes held in the history ring.
	localparam int CODE_W = 3;
	typedef logic [CODE_W-1:0] code_t;
	localparam code_t CODE_A       = 3'd0;
	localparam code_t CODE_C       = 3'd1;
	localparam code_t CODE_G       = 3'd2;
	localparam code_t CODE_T       = 3'd3;
	localparam code_t CODE_INVALID = 3'd4;

	// Sequence characters.
	localparam logic [7:0] CHAR_A_UP = 8'h41;
	localparam logic [7:0] CHAR_A_LO = 8'h61;
	localparam logic [7:0] CHAR_C_UP = 8'h43;
	localparam logic [7:0] CHAR_C_LO = 8'h63;
	localparam logic [7:0] CHAR_G_UP = 8'h47;
	localparam logic [7:0] CHAR_G_LO = 8'h67;
	localparam logic [7:0] CHAR_T_UP = 8'h54;
	localparam logic [7:0] CHAR_T_LO = 8'h74;

	typedef logic signed [WEIGHT_BITS-1:0] weight_t;

	// Ring movement commands broadcast to every cell.
	typedef struct packed {
		logic rot_dn;
		logic rot_up;
		logic clear;
	} ring_ctl_t;

	// Registered contribution of one cell.
	typedef struct packed {
		weight_t term;
		logic    bad;
	} cell_term_t;

	// Maps a raw sequence byte to its column, or to the invalid code.
	function automatic code_t base_code(input logic [7:0] ch);
		code_t c;
		unique case (ch)
			CHAR_A_UP, CHAR_A_LO: c = CODE_A;
			CHAR_C_UP, CHAR_C_LO: c = CODE_C;
			CHAR_G_UP, CHAR_G_LO: c = CODE_G;
			CHAR_T_UP, CHAR_T_LO: c = CODE_T;
			default:              c = CODE_INVALID;
		endcase
		return c;
	endfunction

endpackage

>>> rtl/dna_pwm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_pwm_if
// Valid/ready channel interfaces for sequence items and window scores.
// ----------------------------------------------------------------------------
interface dna_pwm_in_if;
	import dna_pwm_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  opcode;
	logic [POS_W-1:0]      weight_position;
	logic [BASE_W-1:0]     weight_base;
	logic signed [WEIGHT_BITS-1:0] weight_value;
	logic [7:0]            base_char;
	logic                  sequence_start;

	modport source (
		output valid, opcode, weight_position, weight_base, weight_value,
		       base_char, sequence_start,
		input  ready
	);
	modport sink (
		input  valid, opcode, weight_position, weight_base, weight_value,
		       base_char, sequence_start,
		output ready
	);
endinterface

interface dna_pwm_out_if;
	import dna_pwm_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [SCORE_W-1:0] score;
	logic                      score_valid;

	modport source (output valid, score, score_valid, input ready);
	modport sink (input valid, score, score_valid, output ready);
endinterface

>>> rtl/dna_pwm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_pwm_cell
// One slot of the history ring with the four weights of its motif position.
// ----------------------------------------------------------------------------
module dna_pwm_cell (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dna_pwm_pkg::ring_ctl_t  ctl,
	input  dna_pwm_pkg::code_t      from_up,
	input  dna_pwm_pkg::code_t      from_dn,
	input  logic                    ins_en,
	input  dna_pwm_pkg::code_t      ins_code,
	input  logic                    wr_en,
	input  logic [dna_pwm_pkg::BASE_W-1:0] wr_base,
	input  dna_pwm_pkg::weight_t    wr_value,
	input  logic                    active,
	input  logic                    adv,
	output dna_pwm_pkg::code_t      code,
	output dna_pwm_pkg::cell_term_t term_s1
);
	import dna_pwm_pkg::*;

	code_t      code_q;
	weight_t    w_q [NUM_BASES];
	cell_term_t term_d;

	assign code = code_q;

	// History slot: insertion wins over clearing, clearing over movement.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q <= CODE_INVALID;
		end else begin
			priority if (ins_en) begin
				code_q <= ins_code;
			end else if (ctl.clear) begin
				code_q <= CODE_INVALID;
			end else if (ctl.rot_dn) begin
				code_q <= from_up;
			end else if (ctl.rot_up) begin
				code_q <= from_dn;
			end
		end
	end

	// Local weights of this motif position.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			w_q[wr_base] <= wr_value;
		end
	end

	// Weight picked by the held base; slots outside the window add nothing.
	always_comb begin
		term_d.term = '0;
		term_d.bad  = 1'b0;
		if (active) begin
			if (code_q == CODE_INVALID) begin
				term_d.bad = 1'b1;
			end else begin
				term_d.term = w_q[code_q[BASE_W-1:0]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			term_s1 <= term_d;
		end
	end

endmodule

>>> rtl/dna_pwm_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_pwm_sum
// Registered adder tree over the cell terms, ending in the output register.
// ----------------------------------------------------------------------------
module dna_pwm_sum (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              v_s1,
	input  dna_pwm_pkg::cell_term_t           terms_s1 [dna_pwm_pkg::MAX_MOTIF_LENGTH],
	output logic                              out_valid,
	output logic signed [dna_pwm_pkg::SCORE_W-1:0] score,
	output logic                              score_valid
);
	import dna_pwm_pkg::*;

	logic signed [S2_W-1:0]    p2_d [G2];
	logic signed [S2_W-1:0]    p2_s2 [G2];
	logic [G2-1:0]             bad2_d;
	logic [G2-1:0]             bad_s2;
	logic                      v_s2;
	logic signed [S3_W-1:0]    p3_d [G3];
	logic signed [S3_W-1:0]    p3_s3 [G3];
	logic [G3-1:0]             bad3_d;
	logic [G3-1:0]             bad_s3;
	logic                      v_s3;
	logic signed [SCORE_W-1:0] sum_d;
	logic signed [SCORE_W-1:0] score_q;
	logic                      score_valid_q;
	logic                      out_valid_q;

	assign out_valid   = out_valid_q;
	assign score       = score_q;
	assign score_valid = score_valid_q;

	// First level: groups of four cell terms.
	always_comb begin
		for (int g = 0; g < G2; g++) begin
			p2_d[g]   = '0;
			bad2_d[g] = 1'b0;
			for (int k = 0; k < GROUP; k++) begin
				p2_d[g]   = p2_d[g] + S2_W'(terms_s1[g*GROUP+k].term);
				bad2_d[g] = bad2_d[g] | terms_s1[g*GROUP+k].bad;
			end
		end
	end

	// Second level: groups of four first-level sums.
	always_comb begin
		for (int g = 0; g < G3; g++) begin
			p3_d[g]   = '0;
			bad3_d[g] = 1'b0;
			for (int k = 0; k < GROUP; k++) begin
				p3_d[g]   = p3_d[g] + S3_W'(p2_s2[g*GROUP+k]);
				bad3_d[g] = bad3_d[g] | bad_s2[g*GROUP+k];
			end
		end
	end

	// Final level: the remaining partial sums.
	always_comb begin
		sum_d = '0;
		for (int g = 0; g < G3; g++) begin
			sum_d = sum_d + SCORE_W'(p3_s3[g]);
		end
	end

	// Tree payload registers.
	always_ff @(posedge clk) begin
		if (adv) begin
			p2_s2  <= p2_d;
			bad_s2 <= bad2_d;
			p3_s3  <= p3_d;
			bad_s3 <= bad3_d;
			if (|bad_s3) begin
				score_q       <= '0;
				score_valid_q <= 1'b0;
			end else begin
				score_q       <= sum_d;
				score_valid_q <= 1'b1;
			end
		end
	end

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			out_valid_q <= v_s3;
		end
	end

endmodule

>>> rtl/dna_pwm_window_scorer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dna_pwm_window_scorer
// Scores every window of a DNA byte stream against a position-weight matrix.
// ----------------------------------------------------------------------------
// Usage:
// seq_in carries load transactions (opcode 0) that write one Q7.8 weight, and
// base transactions (opcode 1) that carry one sequence byte. score_out
// returns one Q12.8 window sum per base once motif_length bases of the
// current sequence have arrived; score_valid is low (score 0) when the
// window held a byte other than A, C, G or T.
// One transaction is taken per cycle while seq_in.ready is high. The score of
// a window passes the cell term, two adder-tree and the output registers.
// The history is a ring of 32 cells aligned so that the cell of each motif
// position holds its base. Writing motif_length realigns the ring one step a
// cycle, and seq_in.ready stays low until the ring is aligned again.
// When score_out stalls, the whole pipeline holds and seq_in.ready drops.
// Reset sets motif_length to 1, empties the history and the base count, and
// clears the pipeline valid bits; weights are undefined until loaded.
// ----------------------------------------------------------------------------
module dna_pwm_window_scorer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           motif_length_wr_en,
	input  logic [dna_pwm_pkg::LEN_W-1:0]  motif_length_wr_data,
	dna_pwm_in_if.sink                     seq_in,
	dna_pwm_out_if.source                  score_out
);
	import dna_pwm_pkg::*;

	logic [POS_W-1:0] len_m1_q;
	logic [POS_W-1:0] len_m1_d;
	logic [LEN_W-1:0] wr_m1;
	logic [POS_W-1:0] align_q;
	logic [LEN_W-1:0] seen_q;
	logic [LEN_W-1:0] seen_d;
	logic             pend_q;
	logic             adv;
	logic             aligned;
	logic             in_acc;
	logic             base_acc;
	logic             load_acc;
	logic             realign_up;
	logic             realign_dn;
	ring_ctl_t        ring_ctl;
	code_t            new_code;
	code_t            codes [MAX_MOTIF_LENGTH];
	cell_term_t       terms_s1 [MAX_MOTIF_LENGTH];

	// Handshake and pipeline advance.
	assign adv          = !score_out.valid || score_out.ready;
	assign aligned      = (align_q == len_m1_q);
	assign seq_in.ready = adv && aligned;
	assign in_acc       = seq_in.valid && seq_in.ready;
	assign base_acc     = in_acc && (seq_in.opcode == OP_BASE);
	assign load_acc     = in_acc && (seq_in.opcode == OP_LOAD);
	assign realign_up   = (align_q < len_m1_q);
	assign realign_dn   = (align_q > len_m1_q);
	assign new_code     = base_code(seq_in.base_char);

	// Ring movement for this cycle.
	always_comb begin
		ring_ctl.rot_dn = base_acc || realign_dn;
		ring_ctl.rot_up = realign_up;
		ring_ctl.clear  = base_acc && seq_in.sequence_start;
	end

	// Motif length write, clamped to 1..MAX and held as length minus one.
	always_comb begin
		wr_m1 = motif_length_wr_data - LEN_W'(1);
		if (motif_length_wr_data == '0) begin
			len_m1_d = '0;
		end else if (motif_length_wr_data > LEN_W'(MAX_MOTIF_LENGTH)) begin
			len_m1_d = POS_W'(MAX_MOTIF_LENGTH - 1);
		end else begin
			len_m1_d = wr_m1[POS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_m1_q <= '0;
		end else if (motif_length_wr_en) begin
			len_m1_q <= len_m1_d;
		end
	end

	// Ring alignment tracks the motif length one step a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			align_q <= '0;
		end else if (realign_up) begin
			align_q <= align_q + POS_W'(1);
		end else if (realign_dn) begin
			align_q <= align_q - POS_W'(1);
		end
	end

	// Base count of the current sequence, saturating at the ring size.
	always_comb begin
		if (seq_in.sequence_start) begin
			seen_d = LEN_W'(1);
		end else if (seen_q < LEN_W'(MAX_MOTIF_LENGTH)) begin
			seen_d = seen_q + LEN_W'(1);
		end else begin
			seen_d = seen_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			pend_q <= 1'b0;
		end else if (adv) begin
			pend_q <= base_acc && (seen_d > {1'b0, len_m1_q});
			if (base_acc) begin
				seen_q <= seen_d;
			end
		end
	end

	// Row of cells; the ring closes from the last cell back to the first.
	for (genvar j = 0; j < MAX_MOTIF_LENGTH; j++) begin : g_cell
		dna_pwm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ring_ctl),
			.from_up  (codes[(j + 1) % MAX_MOTIF_LENGTH]),
			.from_dn  (codes[(j + MAX_MOTIF_LENGTH - 1) % MAX_MOTIF_LENGTH]),
			.ins_en   (base_acc && (len_m1_q == POS_W'(j))),
			.ins_code (new_code),
			.wr_en    (load_acc && (seq_in.weight_position == POS_W'(j))),
			.wr_base  (seq_in.weight_base),
			.wr_value (seq_in.weight_value),
			.active   (POS_W'(j) <= len_m1_q),
			.adv      (adv),
			.code     (codes[j]),
			.term_s1  (terms_s1[j])
		);
	end

	// Window sum and output register.
	logic v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pend_q;
		end
	end

	dna_pwm_sum u_sum (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.v_s1        (v_s1),
		.terms_s1    (terms_s1),
		.out_valid   (score_out.valid),
		.score       (score_out.score),
		.score_valid (score_out.score_valid)
	);

endmodule
